// File: design/i2cbl_pkg.sv
// ----------------------------------------------------------------------------
// I2C bit-level master package
// Command codes and the item types carried on the command and result channels.
// ----------------------------------------------------------------------------
package i2cbl_pkg;

  localparam int unsigned DelayW  = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ReqW    = 3;

  localparam logic [DelayW-1:0] DelayReset = 16'd20;

  typedef enum logic [ReqW-1:0] {
    CmdStart   = 3'd0,
    CmdStop    = 3'd1,
    CmdWrite   = 3'd2,
    CmdWaitAck = 3'd3,
    CmdRead    = 3'd4,
    CmdProbe   = 3'd5
  } cmd_e;

  typedef struct packed {
    logic             cmd_valid;
    logic [ReqW-1:0]  req_type;
    logic [ByteW-1:0] tx_byte;
    logic             send_ack;
    logic             sda_in;
  } cmd_t;

  typedef struct packed {
    logic             scl_out;
    logic             sda_out;
    logic             busy_res;
    logic             done_res;
    logic [ByteW-1:0] rx_byte;
    logic             nack_seen;
  } res_t;

endpackage

// File: design/i2cbl_cmd_if.sv
// ----------------------------------------------------------------------------
// I2C bit-level master command channel
// Valid/ready channel carrying one tick item of command and bus sample.
// ----------------------------------------------------------------------------
interface i2cbl_cmd_if;
  logic              valid;
  logic              ready;
  i2cbl_pkg::cmd_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: design/i2cbl_res_if.sv
// ----------------------------------------------------------------------------
// I2C bit-level master result channel
// Valid/ready channel carrying one item of pin drive and status per tick.
// ----------------------------------------------------------------------------
interface i2cbl_res_if;
  logic              valid;
  logic              ready;
  i2cbl_pkg::res_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: design/i2c_bit_level_master.sv
// ----------------------------------------------------------------------------
// I2C bit-level master
// Bit engine for start, stop, byte write, acknowledge wait, byte read and
// address probe; one input item is one timing tick of the engine.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i carries one tick item: an optional command (taken only while the
//   engine is idle) and the sampled SDA level. res_o returns exactly one item
//   per accepted tick: SCL/SDA drive, busy, done pulse, last read byte and
//   last acknowledge sample.
//   cfg_we_i/cfg_wdata_i write the phase hold time in ticks (0 acts as 1);
//   write it only while the engine is idle.
//   Result: the result of a tick is registered and shown in the cycle after its acceptance.
//   Throughput: one item per cycle while res_o.ready is high; the phase state
//   update and the result register sit in a single pass of logic, so items follow back to back.
//   Stall: the result register holds while res_o.ready is low, and cmd_i
//   stays ready as long as that register is empty or being emptied.
//   Reset: engine idle, both lines released, hold time 20 ticks, no result
//   pending.
// ----------------------------------------------------------------------------
module i2c_bit_level_master (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [i2cbl_pkg::DelayW-1:0]     cfg_wdata_i,
  i2cbl_cmd_if.sink                        cmd_i,
  i2cbl_res_if.source                      res_o
);
  import i2cbl_pkg::*;

  localparam logic [3:0] PhIdle    = 4'd0;
  localparam logic [3:0] PhStA     = 4'd1;
  localparam logic [3:0] PhStB     = 4'd2;
  localparam logic [3:0] PhStC     = 4'd3;
  localparam logic [3:0] PhWrData  = 4'd4;
  localparam logic [3:0] PhWrHigh  = 4'd5;
  localparam logic [3:0] PhWrLow   = 4'd6;
  localparam logic [3:0] PhAkRel   = 4'd7;
  localparam logic [3:0] PhAkHigh  = 4'd8;
  localparam logic [3:0] PhAkLow   = 4'd9;
  localparam logic [3:0] PhRdHigh  = 4'd10;
  localparam logic [3:0] PhRdLow   = 4'd11;
  localparam logic [3:0] PhRaDrive = 4'd12;
  localparam logic [3:0] PhRaHigh  = 4'd13;
  localparam logic [3:0] PhRaLow   = 4'd14;
  localparam logic [3:0] PhSpA     = 4'd15;

  localparam logic [2:0] LastBit = 3'd7;

  logic [DelayW-1:0] delay_q;
  logic [3:0]        phase_q, phase_d;
  logic [2:0]        bit_q, bit_d;
  logic [DelayW-1:0] cnt_q, cnt_d;
  logic [ByteW-1:0]  shift_q, shift_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic [ReqW-1:0]   cmd_q, cmd_d;
  logic              ack_q, ack_d;
  logic              nack_q, nack_d;
  logic [ByteW-1:0]  rx_q, rx_d;
  logic              done;

  logic              res_valid_q;
  res_t              res_q;

  logic              accept;
  logic [DelayW-1:0] limit;
  logic [DelayW-1:0] cnt_inc;
  logic              probe;
  logic              enter_en;
  logic [3:0]        enter_ph;
  cmd_t              item;

  assign item     = cmd_i.payload;
  assign cmd_i.ready = !res_valid_q || res_o.ready;
  assign accept   = cmd_i.valid && cmd_i.ready;
  assign limit    = (delay_q == '0) ? {{(DelayW-1){1'b0}}, 1'b1} : delay_q;
  assign cnt_inc  = cnt_q + {{(DelayW-1){1'b0}}, 1'b1};
  assign probe    = (cmd_q == ReqW'(CmdProbe));

  always_comb begin
    phase_d  = phase_q;
    bit_d    = bit_q;
    cnt_d    = cnt_q;
    shift_d  = shift_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    cmd_d    = cmd_q;
    ack_d    = ack_q;
    nack_d   = nack_q;
    rx_d     = rx_q;
    done     = 1'b0;
    enter_en = 1'b0;
    enter_ph = PhIdle;

    if (phase_q == PhIdle) begin
      if (item.cmd_valid && item.req_type <= ReqW'(CmdProbe)) begin
        cmd_d    = item.req_type;
        bit_d    = '0;
        enter_en = 1'b1;
        case (item.req_type)
          ReqW'(CmdStart):   enter_ph = PhStA;
          ReqW'(CmdStop):    enter_ph = PhSpA;
          ReqW'(CmdWrite): begin
            shift_d  = item.tx_byte;
            enter_ph = PhWrData;
          end
          ReqW'(CmdWaitAck): enter_ph = PhAkRel;
          ReqW'(CmdRead): begin
            ack_d    = item.send_ack;
            shift_d  = '0;
            enter_ph = PhRdHigh;
          end
          default: begin
            shift_d  = item.tx_byte;
            enter_ph = PhStA;
          end
        endcase
      end
    end else begin
      cnt_d = cnt_inc;
      if (cnt_inc >= limit) begin
        // end of phase: pick the next one or finish the command
        enter_en = 1'b1;
        unique case (phase_q)
          PhStA:    enter_ph = PhStB;
          PhStB:    enter_ph = PhStC;
          PhStC: begin
            if (probe) begin
              bit_d    = '0;
              enter_ph = PhWrData;
            end else begin
              enter_en = 1'b0;
              done     = 1'b1;
            end
          end
          PhWrData: enter_ph = PhWrHigh;
          PhWrHigh: enter_ph = PhWrLow;
          PhWrLow: begin
            if (bit_q != LastBit) begin
              bit_d    = bit_q + 3'd1;
              enter_ph = PhWrData;
            end else if (probe) begin
              enter_ph = PhAkRel;
            end else begin
              enter_en = 1'b0;
              done     = 1'b1;
            end
          end
          PhAkRel:  enter_ph = PhAkHigh;
          PhAkHigh: begin
            nack_d   = item.sda_in;
            enter_ph = PhAkLow;
          end
          PhAkLow: begin
            if (probe) begin
              enter_ph = PhSpA;
            end else begin
              enter_en = 1'b0;
              done     = 1'b1;
            end
          end
          PhRdHigh: begin
            shift_d  = {shift_q[ByteW-2:0], item.sda_in};
            enter_ph = PhRdLow;
          end
          PhRdLow: begin
            if (bit_q != LastBit) begin
              bit_d    = bit_q + 3'd1;
              enter_ph = PhRdHigh;
            end else begin
              enter_ph = PhRaDrive;
            end
          end
          PhRaDrive: enter_ph = PhRaHigh;
          PhRaHigh:  enter_ph = PhRaLow;
          PhRaLow: begin
            enter_en = 1'b0;
            done     = 1'b1;
            sda_d    = 1'b1;
            rx_d     = shift_q;
          end
          PhSpA: begin
            enter_en = 1'b0;
            done     = 1'b1;
            sda_d    = 1'b1;
          end
          default: begin
            enter_en = 1'b0;
            done     = 1'b1;
          end
        endcase
        if (done) begin
          phase_d = PhIdle;
          cnt_d   = '0;
        end
      end
    end

    // drive the levels of the phase being entered
    if (enter_en) begin
      phase_d = enter_ph;
      cnt_d   = '0;
      unique case (enter_ph)
        PhStA: begin
          scl_d = 1'b1;
          sda_d = 1'b1;
        end
        PhStB:    sda_d = 1'b0;
        PhStC:    scl_d = 1'b0;
        PhWrData: sda_d = shift_d[ByteW-1];
        PhWrHigh: scl_d = 1'b1;
        PhWrLow: begin
          scl_d = 1'b0;
          if (bit_d == LastBit) sda_d = 1'b1;
          shift_d = {shift_d[ByteW-2:0], 1'b0};
        end
        PhAkRel:  sda_d = 1'b1;
        PhAkHigh: scl_d = 1'b1;
        PhAkLow:  scl_d = 1'b0;
        PhRdHigh: begin
          scl_d = 1'b1;
          sda_d = 1'b1;
        end
        PhRdLow:   scl_d = 1'b0;
        PhRaDrive: sda_d = !ack_d;
        PhRaHigh:  scl_d = 1'b1;
        PhRaLow:   scl_d = 1'b0;
        PhSpA: begin
          scl_d = 1'b1;
          sda_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DelayReset;
    end else if (cfg_we_i) begin
      delay_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      bit_q   <= '0;
      cnt_q   <= '0;
      shift_q <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      cmd_q   <= '0;
      ack_q   <= 1'b0;
      nack_q  <= 1'b0;
      rx_q    <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      bit_q   <= bit_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      cmd_q   <= cmd_d;
      ack_q   <= ack_d;
      nack_q  <= nack_d;
      rx_q    <= rx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (accept) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // hold the result while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q.scl_out   <= scl_d;
      res_q.sda_out   <= sda_d;
      res_q.busy_res  <= (phase_d != PhIdle);
      res_q.done_res  <= done;
      res_q.rx_byte   <= rx_d;
      res_q.nack_seen <= nack_d;
    end
  end

  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_q;

  a_idle_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhIdle) |-> (cnt_q == '0))
    else $error("delay count not cleared while idle");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.done_res) |-> !res_q.busy_res)
    else $error("completed command still reported busy");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> res_valid_q)
    else $error("accepted item produced no result");

  a_write_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhWrData || phase_q == PhWrHigh || phase_q == PhWrLow) |->
    (cmd_q == ReqW'(CmdWrite) || cmd_q == ReqW'(CmdProbe)))
    else $error("write phase outside write or probe command");

  a_read_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhRdHigh || phase_q == PhRdLow || phase_q == PhRaDrive) |->
    (cmd_q == ReqW'(CmdRead)))
    else $error("read phase outside read command");

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// I2C bit-level master testbench
// Feeds timing ticks with commands and SDA samples into the engine, tracks the
// expected SCL/SDA drive and status per tick in a line tracker, and compares
// every returned item field by field. Short commands at the reset hold time
// come first, then directed commands at a one-tick hold time, then a zero
// hold time, then random bus transfers and other commands over short hold times,
// first without and then with random gaps on both channels.
// ----------------------------------------------------------------------------
package i2cbl_tb_pkg;
  import i2cbl_pkg::*;

  localparam logic [ReqW-1:0] ReqSpareLo = 3'd6;
  localparam logic [ReqW-1:0] ReqSpareHi = 3'd7;
  localparam int unsigned     LastBit    = ByteW - 1;

  typedef enum logic [4:0] {
    PhIdle, PhStA, PhStB, PhStC, PhWrData, PhWrHigh, PhWrLow, PhAkRel, PhAkHigh,
    PhAkLow, PhRdHigh, PhRdLow, PhRaDrive, PhRaHigh, PhRaLow, PhSpA
  } phase_e;

  class i2c_line_tracker;
    logic [DelayW-1:0] hold;
    phase_e            ph;
    logic [3:0]        bit_idx;
    logic [DelayW-1:0] count;
    logic [ByteW-1:0]  shifter;
    logic              scl;
    logic              sda_lvl;
    cmd_e              act;
    logic              ack_sel;
    logic              nack;
    logic [ByteW-1:0]  rx_last;
    res_t              lines_due[$];
    int unsigned       errors;
    int unsigned       worked;

    function new();
      hold    = DelayReset;
      ph      = PhIdle;
      bit_idx = '0;
      count   = '0;
      shifter = '0;
      scl     = 1'b1;
      sda_lvl = 1'b1;
      act     = CmdStart;
      ack_sel = 1'b0;
      nack    = 1'b0;
      rx_last = '0;
      errors  = 0;
      worked  = 0;
    endfunction

    function bit busy();
      return ph != PhIdle;
    endfunction

    function int unsigned pending();
      return lines_due.size();
    endfunction

    // Enter a phase and drive the levels it calls for.
    function void enter(phase_e p);
      ph    = p;
      count = '0;
      case (p)
        PhStA: begin
          scl     = 1'b1;
          sda_lvl = 1'b1;
        end
        PhStB:    sda_lvl = 1'b0;
        PhStC:    scl = 1'b0;
        PhWrData: sda_lvl = shifter[ByteW-1];
        PhWrHigh: scl = 1'b1;
        PhWrLow: begin
          scl = 1'b0;
          if (bit_idx == LastBit) sda_lvl = 1'b1;
          shifter = shifter << 1;
        end
        PhAkRel:  sda_lvl = 1'b1;
        PhAkHigh: scl = 1'b1;
        PhAkLow:  scl = 1'b0;
        PhRdHigh: begin
          scl     = 1'b1;
          sda_lvl = 1'b1;
        end
        PhRdLow:   scl = 1'b0;
        PhRaDrive: sda_lvl = ~ack_sel;
        PhRaHigh:  scl = 1'b1;
        PhRaLow:   scl = 1'b0;
        PhSpA: begin
          scl     = 1'b1;
          sda_lvl = 1'b0;
        end
        default: ;
      endcase
    endfunction

    // Close the current phase; return 1 when the command completes.
    function bit advance(logic sda);
      bit probe;
      bit closes;
      probe  = (act == CmdProbe);
      closes = 1'b0;
      case (ph)
        PhStA: enter(PhStB);
        PhStB: enter(PhStC);
        PhStC: begin
          if (probe) begin
            bit_idx = '0;
            enter(PhWrData);
          end else begin
            closes = 1'b1;
          end
        end
        PhWrData: enter(PhWrHigh);
        PhWrHigh: enter(PhWrLow);
        PhWrLow: begin
          if (bit_idx < LastBit) begin
            bit_idx = bit_idx + 1'b1;
            enter(PhWrData);
          end else if (probe) begin
            enter(PhAkRel);
          end else begin
            closes = 1'b1;
          end
        end
        PhAkRel: enter(PhAkHigh);
        PhAkHigh: begin
          nack = sda;
          enter(PhAkLow);
        end
        PhAkLow: begin
          if (probe) enter(PhSpA);
          else closes = 1'b1;
        end
        PhRdHigh: begin
          shifter = {shifter[ByteW-2:0], sda};
          enter(PhRdLow);
        end
        PhRdLow: begin
          if (bit_idx < LastBit) begin
            bit_idx = bit_idx + 1'b1;
            enter(PhRdHigh);
          end else begin
            enter(PhRaDrive);
          end
        end
        PhRaDrive: enter(PhRaHigh);
        PhRaHigh:  enter(PhRaLow);
        PhRaLow: begin
          sda_lvl = 1'b1;
          rx_last = shifter;
          closes  = 1'b1;
        end
        PhSpA: begin
          sda_lvl = 1'b1;
          closes  = 1'b1;
        end
        default: closes = 1'b1;
      endcase
      return closes;
    endfunction

    function void take_tick(cmd_t c);
      logic [DelayW-1:0] lim;
      res_t              r;
      logic              fin;
      lim = (hold == '0) ? DelayW'(1) : hold;
      fin = 1'b0;
      if (ph == PhIdle) begin
        if (c.cmd_valid && c.req_type <= CmdProbe) begin
          act     = cmd_e'(c.req_type);
          bit_idx = '0;
          case (act)
            CmdStart:   enter(PhStA);
            CmdStop:    enter(PhSpA);
            CmdWrite: begin
              shifter = c.tx_byte;
              enter(PhWrData);
            end
            CmdWaitAck: enter(PhAkRel);
            CmdRead: begin
              ack_sel = c.send_ack;
              shifter = '0;
              enter(PhRdHigh);
            end
            default: begin
              shifter = c.tx_byte;
              enter(PhStA);
            end
          endcase
        end
      end else begin
        count = count + 1'b1;
        if (count >= lim && advance(c.sda_in)) begin
          ph    = PhIdle;
          count = '0;
          fin   = 1'b1;
        end
      end
      r.scl_out   = scl;
      r.sda_out   = sda_lvl;
      r.busy_res  = (ph != PhIdle);
      r.done_res  = fin;
      r.rx_byte   = rx_last;
      r.nack_seen = nack;
      if (r.busy_res || r.done_res) worked++;
      lines_due.push_back(r);
    endfunction

    function void match(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_lines(res_t got);
      res_t want;
      if (lines_due.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
        return;
      end
      want = lines_due.pop_front();
      match("scl_out", want.scl_out, got.scl_out);
      match("sda_out", want.sda_out, got.sda_out);
      match("busy_res", want.busy_res, got.busy_res);
      match("done_res", want.done_res, got.done_res);
      match("rx_byte", want.rx_byte, got.rx_byte);
      match("nack_seen", want.nack_seen, got.nack_seen);
    endfunction
  endclass
endpackage

module tb;
  import i2cbl_pkg::*;
  import i2cbl_tb_pkg::*;

  localparam int SdaLow  = 0;
  localparam int SdaHigh = 1;
  localparam int SdaRand = 2;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [DelayW-1:0]  cfg_wdata_i;
  bit                 src_idle;
  bit                 sink_idle;
  i2c_line_tracker    lines;

  i2cbl_cmd_if cmd ();
  i2cbl_res_if res ();

  i2c_bit_level_master dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .res_o       (res)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #200_000;
    $display("tb: failure");
    $finish;
  end

  always @(negedge clk_i) begin
    res.ready <= sink_idle ? ($urandom_range(99) >= 9) : 1'b1;
  end

  always @(posedge clk_i) begin
    if (res.valid && res.ready) lines.check_lines(res.payload);
  end

  function automatic logic pick_sda(int mode);
    if (mode == SdaLow) return 1'b0;
    if (mode == SdaHigh) return 1'b1;
    return 1'($urandom_range(1));
  endfunction

  // Offer one tick item and hold it until taken; entered and left at a falling edge.
  task automatic send_tick(cmd_t c);
    if (src_idle && $urandom_range(99) < 5) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    cmd.valid   <= 1'b1;
    cmd.payload <= c;
    do @(posedge clk_i); while (!cmd.ready);
    lines.take_tick(c);
    @(negedge clk_i);
  endtask

  // Issue one command, then tick the engine until it is idle again.
  task automatic run_cmd(logic [ReqW-1:0] req, logic [ByteW-1:0] txb, logic ack,
                         int sda_mode, bit noisy);
    cmd_t c;
    c.cmd_valid = 1'b1;
    c.req_type  = req;
    c.tx_byte   = txb;
    c.send_ack  = ack;
    c.sda_in    = pick_sda(sda_mode);
    send_tick(c);
    while (lines.busy()) begin
      c.cmd_valid = noisy && ($urandom_range(99) < 15);
      c.req_type  = ReqW'($urandom_range(7));
      c.tx_byte   = ByteW'($urandom);
      c.send_ack  = 1'($urandom_range(1));
      c.sda_in    = pick_sda(sda_mode);
      send_tick(c);
    end
  endtask

  task automatic set_hold(logic [DelayW-1:0] v);
    cmd.valid <= 1'b0;
    while (lines.pending() != 0) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    lines.hold = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Start, address, acknowledge, a few data bytes, stop.
  task automatic bus_transfer();
    logic [ByteW-1:0] addr;
    int unsigned      n;
    addr = ByteW'($urandom);
    n    = $urandom_range(1, 3);
    run_cmd(CmdStart, ByteW'($urandom), 1'($urandom_range(1)), SdaRand, 1'b0);
    run_cmd(CmdWrite, addr, 1'($urandom_range(1)), SdaRand, 1'b0);
    run_cmd(CmdWaitAck, ByteW'($urandom), 1'($urandom_range(1)), SdaRand, 1'b0);
    for (int unsigned i = 0; i < n; i++) begin
      if (addr[0]) begin
        // ACK every byte but the last
        run_cmd(CmdRead, ByteW'($urandom), (i != n - 1), SdaRand, 1'b0);
      end else begin
        run_cmd(CmdWrite, ByteW'($urandom), 1'($urandom_range(1)), SdaRand, 1'b0);
        run_cmd(CmdWaitAck, ByteW'($urandom), 1'($urandom_range(1)), SdaRand, 1'b0);
      end
    end
    run_cmd(CmdStop, ByteW'($urandom), 1'($urandom_range(1)), SdaRand, 1'b0);
  endtask

  task automatic random_phase(logic [DelayW-1:0] hold, bit idle_on, int unsigned budget);
    int unsigned goal;
    set_hold(hold);
    src_idle  = idle_on;
    sink_idle = idle_on;
    goal      = lines.worked + budget;
    while (lines.worked < goal) begin
      if ($urandom_range(99) < 70) begin
        bus_transfer();
      end else if ($urandom_range(99) < 15) begin
        run_cmd(CmdProbe, ByteW'($urandom), 1'($urandom_range(1)), SdaRand, 1'b1);
      end else begin
        run_cmd(ReqW'($urandom_range(7)), ByteW'($urandom), 1'($urandom_range(1)),
                SdaRand, 1'b1);
      end
    end
  endtask

  initial begin
    lines       = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    cmd.valid   = 1'b0;
    cmd.payload = '0;
    res.ready   = 1'b0;
    src_idle    = 1'b1;
    sink_idle   = 1'b1;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Short commands at the reset hold time
    run_cmd(CmdStart, 8'h00, 1'b0, SdaRand, 1'b0);
    run_cmd(CmdStop, 8'h00, 1'b0, SdaRand, 1'b0);
    run_cmd(ReqSpareLo, 8'h3C, 1'b1, SdaRand, 1'b0);

    // Directed commands at a one-tick hold time
    set_hold(DelayW'(1));
    run_cmd(CmdStart, 8'h00, 1'b0, SdaRand, 1'b0);
    run_cmd(CmdWrite, 8'hFF, 1'b0, SdaRand, 1'b0);
    run_cmd(CmdWrite, 8'h00, 1'b1, SdaRand, 1'b0);
    run_cmd(CmdWaitAck, 8'h00, 1'b0, SdaLow, 1'b0);
    run_cmd(CmdWaitAck, 8'h00, 1'b0, SdaHigh, 1'b0);
    run_cmd(CmdRead, 8'h00, 1'b1, SdaRand, 1'b0);
    run_cmd(CmdRead, 8'h00, 1'b0, SdaHigh, 1'b0);
    run_cmd(CmdRead, 8'h00, 1'b1, SdaLow, 1'b0);
    run_cmd(CmdStop, 8'h00, 1'b0, SdaRand, 1'b0);
    run_cmd(CmdProbe, 8'hA5, 1'b0, SdaLow, 1'b0);
    run_cmd(CmdProbe, 8'h5A, 1'b1, SdaHigh, 1'b0);
    run_cmd(ReqSpareHi, 8'hC3, 1'b0, SdaRand, 1'b0);
    // Commands offered while busy are dropped
    run_cmd(CmdStart, 8'h00, 1'b0, SdaRand, 1'b1);
    run_cmd(CmdStop, 8'h00, 1'b0, SdaRand, 1'b1);

    // Zero hold time behaves as one tick
    set_hold('0);
    run_cmd(CmdStart, 8'h00, 1'b0, SdaRand, 1'b0);
    run_cmd(CmdWrite, ByteW'($urandom), 1'b0, SdaRand, 1'b0);
    run_cmd(CmdRead, 8'h00, 1'b0, SdaRand, 1'b1);
    run_cmd(CmdStop, 8'h00, 1'b0, SdaRand, 1'b0);

    random_phase(DelayW'(1), 1'b0, 120);
    random_phase(DelayW'(2), 1'b1, 100);
    random_phase(DelayW'(1), 1'b1, 100);

    cmd.valid <= 1'b0;
    while (lines.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (lines.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
